FILE: design/tvig_pkg.sv
// tvig_pkg: shared widths, constants, types and helpers for the torus
// vertex and index generator. No dependencies.
package tvig_pkg;

   // fixed field widths
   localparam int SEG_W    = 9;
   localparam int RAD_W    = 16;
   localparam int REM_W    = 9;
   localparam int POS_W    = 25;
   localparam int NORM_W   = 16;
   localparam int TEX_W    = 17;
   localparam int TEX_FRAC = 16;
   localparam int IDX_W    = 17;
   localparam int TRIG_W   = 32;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   // sine/cosine unit latency in cycles
   localparam int SC_LAT   = 11;

   // pi/2 in Q30
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

   // reciprocals for exact floor division of values below 2^30
   localparam logic [30:0] MAG_6  = 31'd1431655766;  // >> 33
   localparam logic [30:0] MAG_20 = 31'd1717986919;  // >> 35
   localparam logic [30:0] MAG_42 = 31'd1636178018;  // >> 36
   localparam logic [30:0] MAG_12 = 31'd1431655766;  // >> 34
   localparam logic [30:0] MAG_30 = 31'd1145324613;  // >> 35
   localparam logic [30:0] MAG_56 = 31'd1227133514;  // >> 36

   // register map
   typedef enum logic [1:0] {
      CSR_MAJOR_RADIUS   = 2'd0,
      CSR_MINOR_RADIUS   = 2'd1,
      CSR_MAJOR_SEGMENTS = 2'd2,
      CSR_MINOR_SEGMENTS = 2'd3
   } csr_reg_type;

   typedef enum logic {
      OP_VERTEX = 1'b0,
      OP_QUAD   = 1'b1
   } opcode_type;

   // sideband carried alongside the divider cells
   typedef struct packed {
      logic             valid;
      logic             opcode;
      logic [IDX_W-1:0] corner;
   } div_side_type;

   // sideband carried alongside the trig and geometry stages
   typedef struct packed {
      logic             valid;
      logic             opcode;
      logic [IDX_W-1:0] corner;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
   } post_side_type;

   function automatic logic [59:0] mul30(input logic [29:0] a, input logic [29:0] b);
      return {30'b0, a} * {30'b0, b};
   endfunction

   function automatic logic [60:0] mulmag(input logic [29:0] a, input logic [30:0] b);
      return {31'b0, a} * {30'b0, b};
   endfunction

   // clamp to signed 16 bits
   function automatic logic [NORM_W-1:0] sat_norm(input logic signed [23:0] x);
      if (x > 24'sd32767) begin
         return 16'h7FFF;
      end else if (x < -24'sd32768) begin
         return 16'h8000;
      end
      return x[NORM_W-1:0];
   endfunction

endpackage

FILE: design/torus_vertex_and_index_generator.sv
// Channel   Direction  Handshake             Moves
// req_*     in         req_valid/req_ready   opcode, ring_step, tube_step
// rsp_*     out        rsp_valid/rsp_ready   position, normal, texture, corners, last
// APB       in/out     psel/penable/pready   four geometry registers
//
// One transaction accepted per cycle unless a stall on rsp or the first result of a
// quad holds the pipeline. From request handshake to result handshake the data runs
// through the row of division cells (one quotient bit per cell) and the sine unit.
// A vertex gives one result, a quad two consecutive results that share the result
// register. A stall on rsp holds the whole pipeline, req_ready drops with it.
// Synchronous reset clears valid state and sets the registers to their defaults.
// Depends on tvig_pkg, tvig_div_cell, tvig_sincos.
module torus_vertex_and_index_generator #(
   parameter int MAX_SEGMENTS = 256,
   parameter int ANGLE_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [tvig_pkg::SEG_W-1:0]          req_ring_step,
   input  logic [tvig_pkg::SEG_W-1:0]          req_tube_step,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tvig_pkg::POS_W-1:0]   rsp_pos_x,
   output logic signed [tvig_pkg::POS_W-1:0]   rsp_pos_y,
   output logic signed [tvig_pkg::POS_W-1:0]   rsp_pos_z,
   output logic signed [tvig_pkg::NORM_W-1:0]  rsp_norm_x,
   output logic signed [tvig_pkg::NORM_W-1:0]  rsp_norm_y,
   output logic signed [tvig_pkg::NORM_W-1:0]  rsp_norm_z,
   output logic [tvig_pkg::TEX_W-1:0]          rsp_tex_u,
   output logic [tvig_pkg::TEX_W-1:0]          rsp_tex_v,
   output logic [tvig_pkg::IDX_W-1:0]          rsp_corner_a,
   output logic [tvig_pkg::IDX_W-1:0]          rsp_corner_b,
   output logic [tvig_pkg::IDX_W-1:0]          rsp_corner_c,
   output logic                                rsp_last,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tvig_pkg::ADDR_W-1:0]         paddr,
   input  logic [tvig_pkg::DATA_W-1:0]         pwdata,
   output logic [tvig_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);
   import tvig_pkg::*;

   localparam int L  = (ANGLE_BITS > TEX_FRAC) ? ANGLE_BITS : TEX_FRAC;
   localparam int QW = L + 1;
   localparam int PL = SC_LAT + 3;
   localparam int ND = 4;

   // ---------------- configuration registers ----------------
   logic [RAD_W-1:0] major_ff, minor_ff;
   logic [SEG_W-1:0] mseg_ff, nseg_ff;
   logic             csr_wr;
   csr_reg_type      csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_sel = csr_reg_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff <= RAD_W'(256);
         minor_ff <= RAD_W'(128);
         mseg_ff  <= SEG_W'(32);
         nseg_ff  <= SEG_W'(16);
      end else if (csr_wr) begin
         unique case (csr_sel)
            CSR_MAJOR_RADIUS:   major_ff <= pwdata[RAD_W-1:0];
            CSR_MINOR_RADIUS:   minor_ff <= pwdata[RAD_W-1:0];
            CSR_MAJOR_SEGMENTS: mseg_ff  <= pwdata[SEG_W-1:0];
            CSR_MINOR_SEGMENTS: nseg_ff  <= pwdata[SEG_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_sel)
         CSR_MAJOR_RADIUS:   prdata = DATA_W'(major_ff);
         CSR_MINOR_RADIUS:   prdata = DATA_W'(minor_ff);
         CSR_MAJOR_SEGMENTS: prdata = DATA_W'(mseg_ff);
         CSR_MINOR_SEGMENTS: prdata = DATA_W'(nseg_ff);
         default:            prdata = '0;
      endcase
   end

   // effective segment counts
   logic [SEG_W-1:0] m_eff, n_eff;
   always_comb begin
      if (mseg_ff == '0) begin
         m_eff = SEG_W'(1);
      end else if (int'(mseg_ff) > MAX_SEGMENTS) begin
         m_eff = SEG_W'(MAX_SEGMENTS);
      end else begin
         m_eff = mseg_ff;
      end
      if (nseg_ff == '0) begin
         n_eff = SEG_W'(1);
      end else if (int'(nseg_ff) > MAX_SEGMENTS) begin
         n_eff = SEG_W'(MAX_SEGMENTS);
      end else begin
         n_eff = nseg_ff;
      end
   end

   // ---------------- flow control ----------------
   logic out_v_ff, beat_ff, op_ff;
   logic final_beat, adv;

   assign final_beat = (op_ff == OP_VERTEX) || beat_ff;
   assign adv        = !out_v_ff || (rsp_ready && final_beat);
   assign req_ready  = adv;

   // ---------------- input clamp and divider seed ----------------
   logic [SEG_W-1:0] iv, jv, iq, jq;
   logic [SEG_W:0]   n_plus1;
   logic [18:0]      c_full;

   assign iv      = (req_ring_step > m_eff) ? m_eff : req_ring_step;
   assign jv      = (req_tube_step > n_eff) ? n_eff : req_tube_step;
   assign iq      = (req_ring_step > m_eff - SEG_W'(1)) ? m_eff - SEG_W'(1) : req_ring_step;
   assign jq      = (req_tube_step > n_eff - SEG_W'(1)) ? n_eff - SEG_W'(1) : req_tube_step;
   assign n_plus1 = {1'b0, n_eff} + (SEG_W + 1)'(1);
   assign c_full  = ({10'b0, iq} * {9'b0, n_plus1}) + {10'b0, jq};

   logic [SEG_W-1:0] div_divisor [ND];
   logic [SEG_W-1:0] div_dividend [ND];
   assign div_divisor[0]  = m_eff;
   assign div_divisor[1]  = n_eff;
   assign div_divisor[2]  = m_eff;
   assign div_divisor[3]  = n_eff;
   assign div_dividend[0] = iv;
   assign div_dividend[1] = jv;
   assign div_dividend[2] = iv;
   assign div_dividend[3] = jv;

   logic [REM_W-1:0] rem0_ff [ND];
   logic [QW-1:0]    quo0_ff [ND];

   // top quotient bit: index equal to the count
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int d = 0; d < ND; d++) begin
            rem0_ff[d] <= (div_dividend[d] == div_divisor[d]) ? '0 : div_dividend[d];
            quo0_ff[d] <= QW'(div_dividend[d] == div_divisor[d]);
         end
      end
   end

   // ---------------- division cell rows ----------------
   // rows 0/1: angles u/v, rows 2/3: texture u/v
   logic [REM_W-1:0] rem_w [ND][L+1];
   logic [QW-1:0]    quo_w [ND][L+1];

   genvar d, k;
   generate
      for (d = 0; d < ND; d++) begin : g_row
         assign rem_w[d][0] = rem0_ff[d];
         assign quo_w[d][0] = quo0_ff[d];
         for (k = 0; k < L; k++) begin : g_cell
            tvig_div_cell #(
               .QW    (QW),
               .SHIFT ((d < 2) ? ANGLE_BITS : TEX_FRAC),
               .STEP  (k)
            ) u_cell (
               .clock   (clock),
               .adv     (adv),
               .divisor (div_divisor[d]),
               .rem_in  (rem_w[d][k]),
               .quo_in  (quo_w[d][k]),
               .rem_out (rem_w[d][k+1]),
               .quo_out (quo_w[d][k+1])
            );
         end
      end
   endgenerate

   // ---------------- sideband pipelines ----------------
   div_side_type  div_pipe_ff  [L+1];
   post_side_type post_pipe_ff [PL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= L; s++) begin
            div_pipe_ff[s] <= '0;
         end
         for (int s = 0; s < PL; s++) begin
            post_pipe_ff[s] <= '0;
         end
      end else if (adv) begin
         div_pipe_ff[0] <= '{valid: req_valid, opcode: req_opcode, corner: c_full[IDX_W-1:0]};
         for (int s = 1; s <= L; s++) begin
            div_pipe_ff[s] <= div_pipe_ff[s-1];
         end
         post_pipe_ff[0] <= '{valid:  div_pipe_ff[L].valid,
                              opcode: div_pipe_ff[L].opcode,
                              corner: div_pipe_ff[L].corner,
                              tex_u:  quo_w[2][L][TEX_W-1:0],
                              tex_v:  quo_w[3][L][TEX_W-1:0]};
         for (int s = 1; s < PL; s++) begin
            post_pipe_ff[s] <= post_pipe_ff[s-1];
         end
      end
   end

   // ---------------- sine and cosine ----------------
   logic signed [TRIG_W-1:0] su, cu, sv, cv;

   tvig_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_u (
      .clock   (clock),
      .adv     (adv),
      .angle   (quo_w[0][L][ANGLE_BITS-1:0]),
      .sin_out (su),
      .cos_out (cu)
   );

   tvig_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_v (
      .clock   (clock),
      .adv     (adv),
      .angle   (quo_w[1][L][ANGLE_BITS-1:0]),
      .sin_out (sv),
      .cos_out (cv)
   );

   // ---------------- geometry ----------------
   logic signed [48:0]       rc_ff, ss_ff;
   logic signed [63:0]       ncu_ff, nsu_ff;
   logic [NORM_W-1:0]        nz1_ff, nz2_ff, nz3_ff;
   logic signed [TRIG_W-1:0] cu1_ff, su1_ff, cu2_ff, su2_ff;
   logic signed [31:0]       radial_ff;
   logic [POS_W-1:0]         pz2_ff, pz3_ff;
   logic [NORM_W-1:0]        nx2_ff, ny2_ff, nx3_ff, ny3_ff;
   logic signed [63:0]       px_ff, py_ff;

   logic signed [31:0] nz_round;
   logic signed [48:0] rc_round, ss_round;
   logic signed [63:0] nx_round, ny_round, px_round, py_round;

   assign nz_round = (sv + 32'sd16384) >>> 15;
   assign rc_round = (rc_ff + 49'sd32768) >>> 16;
   assign ss_round = (ss_ff + 49'sd8388608) >>> 24;
   assign nx_round = (ncu_ff + 64'sd17592186044416) >>> 45;
   assign ny_round = (nsu_ff + 64'sd17592186044416) >>> 45;
   assign px_round = (px_ff + 64'sd137438953472) >>> 38;
   assign py_round = (py_ff + 64'sd137438953472) >>> 38;

   always_ff @(posedge clock) begin
      if (adv) begin
         // products of radius and angle terms
         rc_ff  <= $signed({1'b0, minor_ff}) * cv;
         ss_ff  <= $signed({1'b0, minor_ff}) * sv;
         ncu_ff <= cv * cu;
         nsu_ff <= cv * su;
         nz1_ff <= sat_norm(nz_round[23:0]);
         cu1_ff <= cu;
         su1_ff <= su;
         // tube center distance, z and normals
         radial_ff <= $signed({2'b0, major_ff, 14'b0}) + $signed(rc_round[31:0]);
         pz2_ff    <= ss_round[POS_W-1:0];
         nx2_ff    <= sat_norm(nx_round[23:0]);
         ny2_ff    <= sat_norm(ny_round[23:0]);
         nz2_ff    <= nz1_ff;
         cu2_ff    <= cu1_ff;
         su2_ff    <= su1_ff;
         // ring rotation
         px_ff  <= radial_ff * cu2_ff;
         py_ff  <= radial_ff * su2_ff;
         pz3_ff <= pz2_ff;
         nx3_ff <= nx2_ff;
         ny3_ff <= ny2_ff;
         nz3_ff <= nz2_ff;
      end
   end

   // ---------------- result register ----------------
   post_side_type    tail;
   logic [POS_W-1:0]  px_o_ff, py_o_ff, pz_o_ff;
   logic [NORM_W-1:0] nx_o_ff, ny_o_ff, nz_o_ff;
   logic [TEX_W-1:0]  tu_o_ff, tv_o_ff;
   logic [IDX_W-1:0]  c_o_ff;
   logic              is_vtx;

   assign tail   = post_pipe_ff[PL-1];
   assign is_vtx = (tail.opcode == OP_VERTEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         beat_ff  <= 1'b0;
         op_ff    <= OP_VERTEX;
      end else if (adv) begin
         out_v_ff <= tail.valid;
         beat_ff  <= 1'b0;
         op_ff    <= tail.opcode;
      end else if (rsp_ready) begin
         beat_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_o_ff <= is_vtx ? px_round[POS_W-1:0] : '0;
         py_o_ff <= is_vtx ? py_round[POS_W-1:0] : '0;
         pz_o_ff <= is_vtx ? pz3_ff : '0;
         nx_o_ff <= is_vtx ? nx3_ff : '0;
         ny_o_ff <= is_vtx ? ny3_ff : '0;
         nz_o_ff <= is_vtx ? nz3_ff : '0;
         tu_o_ff <= is_vtx ? tail.tex_u : '0;
         tv_o_ff <= is_vtx ? tail.tex_v : '0;
         c_o_ff  <= tail.corner;
      end
   end

   // triangle corners from the stored base index
   logic [IDX_W-1:0] c_next, nx_idx;
   assign c_next = c_o_ff + IDX_W'(1);
   assign nx_idx = c_o_ff + IDX_W'(n_plus1);

   always_comb begin
      if (op_ff == OP_VERTEX) begin
         rsp_corner_a = '0;
         rsp_corner_b = '0;
         rsp_corner_c = '0;
      end else if (!beat_ff) begin
         rsp_corner_a = c_o_ff;
         rsp_corner_b = nx_idx;
         rsp_corner_c = c_next;
      end else begin
         rsp_corner_a = c_next;
         rsp_corner_b = nx_idx;
         rsp_corner_c = nx_idx + IDX_W'(1);
      end
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_last   = final_beat;
   assign rsp_pos_x  = px_o_ff;
   assign rsp_pos_y  = py_o_ff;
   assign rsp_pos_z  = pz_o_ff;
   assign rsp_norm_x = nx_o_ff;
   assign rsp_norm_y = ny_o_ff;
   assign rsp_norm_z = nz_o_ff;
   assign rsp_tex_u  = tu_o_ff;
   assign rsp_tex_v  = tv_o_ff;

endmodule

FILE: design/tvig_div_cell.sv
// tvig_div_cell: one restoring-division cell, one quotient bit per cycle while adv is high.
// Depends on tvig_pkg.
module tvig_div_cell #(
   parameter int QW    = 17,
   parameter int SHIFT = 16,
   parameter int STEP  = 0
) (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [tvig_pkg::SEG_W-1:0] divisor,
   input  logic [tvig_pkg::REM_W-1:0] rem_in,
   input  logic [QW-1:0]              quo_in,
   output logic [tvig_pkg::REM_W-1:0] rem_out,
   output logic [QW-1:0]              quo_out
);
   import tvig_pkg::*;

   logic [REM_W-1:0] rem_ff;
   logic [QW-1:0]    quo_ff;
   logic [REM_W-1:0] rem_in_w;
   logic [QW-1:0]    quo_in_w;

   generate
      if (STEP < SHIFT) begin : g_active
         localparam int HB = SHIFT - 1 - STEP;
         logic          hbit;
         logic [REM_W:0] trial;
         logic           ge;

         // dividend low part is divisor/2, so its bits come from the divisor
         if (HB < SEG_W - 1) begin : g_hb
            assign hbit = divisor[HB+1];
         end else begin : g_hz
            assign hbit = 1'b0;
         end

         assign trial    = {rem_in, hbit};
         assign ge       = trial >= {1'b0, divisor};
         assign rem_in_w = ge ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
         assign quo_in_w = {quo_in[QW-2:0], ge};
      end else begin : g_pass
         assign rem_in_w = rem_in;
         assign quo_in_w = quo_in;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in_w;
         quo_ff <= quo_in_w;
      end
   end

   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule

FILE: design/tvig_sincos.sv
// tvig_sincos: pipelined Q30 sine/cosine of a fraction-of-turn angle,
// Taylor series term by term. Depends on tvig_pkg.
module tvig_sincos #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               adv,
   input  logic [ANGLE_BITS-1:0]              angle,
   output logic signed [tvig_pkg::TRIG_W-1:0] sin_out,
   output logic signed [tvig_pkg::TRIG_W-1:0] cos_out
);
   import tvig_pkg::*;

   localparam int QB   = ANGLE_BITS - 2;
   localparam int P_W  = QB + 31;
   localparam int MQ_D = SC_LAT - 1;
   localparam logic [QB-1:0] HALF_Q = QB'(64'd1 << (QB - 1));

   // quadrant folding
   logic [QB-1:0] frac;
   logic          mirror;
   logic [QB-1:0] g;
   assign frac   = angle[QB-1:0];
   assign mirror = frac > HALF_Q;
   assign g      = mirror ? (~frac) + QB'(1) : frac;

   logic [2:0]     mq_ff [MQ_D];
   logic [P_W-1:0] p1_ff;
   logic [P_W:0]   tsum;
   logic [29:0]    t_ff, t3_ff, tsq_ff;
   logic [59:0]    tt;

   assign tsum = {1'b0, p1_ff} + (P_W + 1)'(HALF_Q);
   assign tt   = mul30(t_ff, t_ff);

   // series stages
   logic [30:0] sacc4_ff, sacc5_ff, sacc6_ff, sacc7_ff, sacc8_ff, sacc9_ff, sacc10_ff;
   logic [30:0] cacc4_ff, cacc5_ff, cacc6_ff, cacc7_ff, cacc8_ff, cacc9_ff, cacc10_ff;
   logic [59:0] sprod4_ff, sprod6_ff, sprod8_ff;
   logic [59:0] cprod4_ff, cprod6_ff, cprod8_ff;
   logic [60:0] sq5_ff, sq7_ff, sq9_ff, cq5_ff, cq7_ff, cq9_ff;
   logic [29:0] tsq4_ff, tsq5_ff, tsq6_ff, tsq7_ff;
   logic [29:0] cterm4, sterm6, cterm6, sterm8, cterm8;

   assign cterm4 = {1'b0, tsq_ff[29:1]};
   assign sterm6 = 30'(sq5_ff >> 33);
   assign cterm6 = 30'(cq5_ff >> 34);
   assign sterm8 = 30'(sq7_ff >> 35);
   assign cterm8 = 30'(cq7_ff >> 35);

   always_ff @(posedge clock) begin
      if (adv) begin
         // radians and square
         p1_ff  <= P_W'(g) * P_W'(HALF_PI_Q30);
         t_ff   <= tsum[QB+29:QB];
         tsq_ff <= tt[59:30];
         t3_ff  <= t_ff;
         // first terms
         sacc4_ff  <= {1'b0, t3_ff};
         sprod4_ff <= mul30(t3_ff, tsq_ff);
         cacc4_ff  <= ONE_Q30 - {1'b0, cterm4};
         cprod4_ff <= mul30(cterm4, tsq_ff);
         tsq4_ff   <= tsq_ff;
         // divide by 6 and 12
         sq5_ff   <= mulmag(sprod4_ff[59:30], MAG_6);
         cq5_ff   <= mulmag(cprod4_ff[59:30], MAG_12);
         sacc5_ff <= sacc4_ff;
         cacc5_ff <= cacc4_ff;
         tsq5_ff  <= tsq4_ff;
         // third/fourth order terms
         sacc6_ff  <= sacc5_ff - {1'b0, sterm6};
         sprod6_ff <= mul30(sterm6, tsq5_ff);
         cacc6_ff  <= cacc5_ff + {1'b0, cterm6};
         cprod6_ff <= mul30(cterm6, tsq5_ff);
         tsq6_ff   <= tsq5_ff;
         // divide by 20 and 30
         sq7_ff   <= mulmag(sprod6_ff[59:30], MAG_20);
         cq7_ff   <= mulmag(cprod6_ff[59:30], MAG_30);
         sacc7_ff <= sacc6_ff;
         cacc7_ff <= cacc6_ff;
         tsq7_ff  <= tsq6_ff;
         // fifth/sixth order terms
         sacc8_ff  <= sacc7_ff + {1'b0, sterm8};
         sprod8_ff <= mul30(sterm8, tsq7_ff);
         cacc8_ff  <= cacc7_ff - {1'b0, cterm8};
         cprod8_ff <= mul30(cterm8, tsq7_ff);
         // divide by 42 and 56
         sq9_ff   <= mulmag(sprod8_ff[59:30], MAG_42);
         cq9_ff   <= mulmag(cprod8_ff[59:30], MAG_56);
         sacc9_ff <= sacc8_ff;
         cacc9_ff <= cacc8_ff;
         // last terms
         sacc10_ff <= sacc9_ff - 31'(sq9_ff >> 36);
         cacc10_ff <= cacc9_ff + 31'(cq9_ff >> 36);
      end
   end

   // mirror and quadrant travel with the data
   always_ff @(posedge clock) begin
      if (adv) begin
         mq_ff[0] <= {mirror, angle[ANGLE_BITS-1:ANGLE_BITS-2]};
         for (int k = 1; k < MQ_D; k++) begin
            mq_ff[k] <= mq_ff[k-1];
         end
      end
   end

   // swap and signs from the quadrant
   logic signed [TRIG_W-1:0] ps, pc, sn_in, cs_in;
   logic signed [TRIG_W-1:0] sin_ff, cos_ff;
   logic [2:0] mq;
   assign mq = mq_ff[MQ_D-1];

   always_comb begin
      ps = mq[2] ? $signed({1'b0, cacc10_ff}) : $signed({1'b0, sacc10_ff});
      pc = mq[2] ? $signed({1'b0, sacc10_ff}) : $signed({1'b0, cacc10_ff});
      case (mq[1:0])
         2'd0:    begin sn_in = ps;  cs_in = pc;  end
         2'd1:    begin sn_in = pc;  cs_in = -ps; end
         2'd2:    begin sn_in = -ps; cs_in = -pc; end
         default: begin sn_in = -pc; cs_in = ps;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff <= sn_in;
         cos_ff <= cs_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

FILE: design/tvig_checker.sv
// tvig_checker: port-level assertions for the torus generator and the bind
// that attaches them. Depends on torus_vertex_and_index_generator.
module tvig_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [24:0] rsp_pos_x,
   input logic [16:0] rsp_corner_a,
   input logic [16:0] rsp_corner_b,
   input logic [16:0] rsp_corner_c,
   input logic        rsp_last
);

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_corner_a) && $stable(rsp_pos_x))
      else $error("stalled result changed");

   // second triangle follows the first at once and shares its edge
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_last && rsp_corner_a == $past(rsp_corner_c))
      else $error("second triangle missing or misaligned");

   // first triangle: third corner is next to the first, no position
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_corner_c == rsp_corner_a + 17'd1 && rsp_pos_x == '0)
      else $error("first triangle malformed");

   // only vertex results carry a zero middle corner
   a_vertex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_corner_b == '0 |-> rsp_last)
      else $error("vertex result not marked last");

   // reset empties the result register
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind torus_vertex_and_index_generator tvig_checker u_tvig_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_pos_x    (rsp_pos_x),
   .rsp_corner_a (rsp_corner_a),
   .rsp_corner_b (rsp_corner_b),
   .rsp_corner_c (rsp_corner_c),
   .rsp_last     (rsp_last)
);

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for torus_vertex_and_index_generator. It drives random and
// directed vertex/quad requests, rewrites the geometry registers between phases and checks
// every result against a built-in fixed-point torus predictor. Depends on tvig_pkg.
`timescale 1ns / 100ps

import tvig_pkg::*;

typedef struct {
   logic signed [24:0] pos_x, pos_y, pos_z;
   logic signed [15:0] norm_x, norm_y, norm_z;
   logic [16:0]        tex_u, tex_v;
   logic [16:0]        corner_a, corner_b, corner_c;
   logic               last;
} torus_result_type;

class tessellation_scoreboard;
   torus_result_type pending_results[$];
   int unsigned   major_r = 256, minor_r = 128, ring_segs = 32, tube_segs = 16;
   int            errors = 0;
   int            vertex_count = 0, quad_count = 0;

   function longint unsigned eff_segs(int unsigned v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   function longint round_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function longint sat16(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
   endfunction

   function longint unsigned turn_angle(longint unsigned i, longint unsigned m);
      return (((i << 16) + (m >> 1)) / m) & 64'hFFFF;
   endfunction

   // Q30 sine/cosine by quadrant, octant mirror and truncated series
   function void sin_cos(longint unsigned a, output longint sn, output longint cs);
      longint unsigned quarter, quad, f, g, t, t2, term, s, c, tmp;
      bit mirror;
      quarter = 64'd1 << 14;
      quad = (a >> 14) & 3;
      f = a & (quarter - 1);
      mirror = f > (quarter >> 1);
      g = mirror ? quarter - f : f;
      t = (g * 64'd1686629713 + (quarter >> 1)) >> 14;
      t2 = (t * t) >> 30;
      term = t; s = t;
      term = ((term * t2) >> 30) / 6;  s -= term;
      term = ((term * t2) >> 30) / 20; s += term;
      term = ((term * t2) >> 30) / 42; s -= term;
      term = 64'd1 << 30; c = term;
      term = ((term * t2) >> 30) / 2;  c -= term;
      term = ((term * t2) >> 30) / 12; c += term;
      term = ((term * t2) >> 30) / 30; c -= term;
      term = ((term * t2) >> 30) / 56; c += term;
      if (mirror) begin
         tmp = s; s = c; c = tmp;
      end
      case (quad)
         0: begin sn = longint'(s);  cs = longint'(c);  end
         1: begin sn = longint'(c);  cs = -longint'(s); end
         2: begin sn = -longint'(s); cs = -longint'(c); end
         default: begin sn = -longint'(c); cs = longint'(s); end
      endcase
   endfunction

   function void write_reg(csr_reg_type idx, logic [31:0] value);
      case (idx)
         CSR_MAJOR_RADIUS:   major_r = 32'(value[15:0]);
         CSR_MINOR_RADIUS:   minor_r = 32'(value[15:0]);
         CSR_MAJOR_SEGMENTS: ring_segs = 32'(value[8:0]);
         CSR_MINOR_SEGMENTS: tube_segs = 32'(value[8:0]);
      endcase
   endfunction

   // work out the results one accepted request will produce
   function void note_request(opcode_type op, logic [8:0] ring, logic [8:0] tube);
      longint unsigned m, n, i, j, c, nx;
      longint su, cu, sv, cv, radial;
      torus_result_type r;
      m = eff_segs(ring_segs);
      n = eff_segs(tube_segs);
      i = 64'(ring);
      j = 64'(tube);
      r = '{default: 0};
      if (op == OP_VERTEX) begin
         vertex_count++;
         if (i > m) i = m;
         if (j > n) j = n;
         sin_cos(turn_angle(i, m), su, cu);
         sin_cos(turn_angle(j, n), sv, cv);
         radial = (longint'(major_r) << 14) + round_shift(longint'(minor_r) * cv, 16);
         r.pos_x = 25'(round_shift(radial * cu, 38));
         r.pos_y = 25'(round_shift(radial * su, 38));
         r.pos_z = 25'(round_shift(longint'(minor_r) * sv, 24));
         r.norm_x = 16'(sat16(round_shift(cv * cu, 45)));
         r.norm_y = 16'(sat16(round_shift(cv * su, 45)));
         r.norm_z = 16'(sat16(round_shift(sv, 15)));
         r.tex_u = 17'(((i << 16) + (m >> 1)) / m);
         r.tex_v = 17'(((j << 16) + (n >> 1)) / n);
         r.last = 1;
         pending_results.push_back(r);
      end else begin
         quad_count++;
         if (i > m - 1) i = m - 1;
         if (j > n - 1) j = n - 1;
         c = i * (n + 1) + j;
         nx = c + n + 1;
         r.corner_a = 17'(c); r.corner_b = 17'(nx); r.corner_c = 17'(c + 1); r.last = 0;
         pending_results.push_back(r);
         r.corner_a = 17'(c + 1); r.corner_b = 17'(nx); r.corner_c = 17'(nx + 1); r.last = 1;
         pending_results.push_back(r);
      end
   endfunction

   function void cmp(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t: %s mismatch expected %0h actual %0h", $time, nm, e, a);
      end
   endfunction

   function void check_result(torus_result_type act);
      torus_result_type e;
      if (pending_results.size() == 0) begin
         errors++;
         $display("%0t: unexpected result transaction, expected none, actual last=%0b",
                  $time, act.last);
         return;
      end
      e = pending_results.pop_front();
      cmp("pos_x", 32'(e.pos_x), 32'(act.pos_x));
      cmp("pos_y", 32'(e.pos_y), 32'(act.pos_y));
      cmp("pos_z", 32'(e.pos_z), 32'(act.pos_z));
      cmp("norm_x", 32'(e.norm_x), 32'(act.norm_x));
      cmp("norm_y", 32'(e.norm_y), 32'(act.norm_y));
      cmp("norm_z", 32'(e.norm_z), 32'(act.norm_z));
      cmp("tex_u", 32'(e.tex_u), 32'(act.tex_u));
      cmp("tex_v", 32'(e.tex_v), 32'(act.tex_v));
      cmp("corner_a", 32'(e.corner_a), 32'(act.corner_a));
      cmp("corner_b", 32'(e.corner_b), 32'(act.corner_b));
      cmp("corner_c", 32'(e.corner_c), 32'(act.corner_c));
      cmp("last", 32'(e.last), 32'(act.last));
   endfunction
endclass

module tb_top;
   logic clock = 0, reset = 1;
   logic req_valid = 0, req_opcode = 0;
   logic [8:0] req_ring_step = 0, req_tube_step = 0;
   logic req_ready, rsp_valid, rsp_ready = 0, rsp_last;
   logic signed [24:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [16:0] rsp_tex_u, rsp_tex_v, rsp_corner_a, rsp_corner_b, rsp_corner_c;
   logic psel = 0, penable = 0, pwrite = 0, pready;
   logic [ADDR_W-1:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   bit no_idle = 0;
   int quiet_cycles = 0;
   tessellation_scoreboard sb = new();

   torus_vertex_and_index_generator i_dut (.*);

   initial forever #10 clock = ~clock;

   function int draw_wait();
      if (no_idle) return 0;
      return $urandom_range(0, 18);
   endfunction

   // send one request; called and returns in posedge context
   task automatic send_request(opcode_type op, logic [8:0] ring, logic [8:0] tube);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_ring_step <= ring;
      req_tube_step <= tube;
      do @(negedge clock); while (!req_ready);
      sb.note_request(op, ring, tube);
      @(posedge clock);
   endtask

   task automatic write_csr(csr_reg_type idx, logic [31:0] value);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= ADDR_W'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.write_reg(idx, value);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_requests(int count);
      int unsigned m, n;
      opcode_type op;
      m = 32'(sb.eff_segs(sb.ring_segs));
      n = 32'(sb.eff_segs(sb.tube_segs));
      repeat (count) begin
         if ($urandom_range(0, 49) == 0) no_idle = ~no_idle;
         op = opcode_type'($urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0)
            send_request(op, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
         else
            send_request(op, 9'($urandom_range(0, m + 1)), 9'($urandom_range(0, n + 1)));
      end
   endtask

   // result side: random stalls, check each accepted transaction
   initial begin
      torus_result_type act;
      int stall;
      @(negedge reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(negedge clock); while (!rsp_valid);
         act = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_norm_x, rsp_norm_y, rsp_norm_z,
                 rsp_tex_u, rsp_tex_v, rsp_corner_a, rsp_corner_b, rsp_corner_c, rsp_last};
         sb.check_result(act);
         @(posedge clock);
      end
   end

   // watchdog: cycles with a request waiting or results outstanding but no handshake
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel ||
          (sb.pending_results.size() == 0 && !req_valid))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= 5000) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  sb.pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, field extremes, quarter turns, clamping
      send_request(OP_VERTEX, 0, 0);
      send_request(OP_VERTEX, 8, 4);
      send_request(OP_VERTEX, 16, 8);
      send_request(OP_VERTEX, 24, 12);
      send_request(OP_VERTEX, 4, 2);
      send_request(OP_VERTEX, 12, 6);
      send_request(OP_VERTEX, 32, 16);
      send_request(OP_VERTEX, 33, 17);
      send_request(OP_VERTEX, 511, 511);
      send_request(OP_VERTEX, 170, 341);
      send_request(OP_VERTEX, 31, 15);
      send_request(OP_QUAD, 0, 0);
      send_request(OP_QUAD, 31, 15);
      send_request(OP_QUAD, 32, 16);
      send_request(OP_QUAD, 511, 511);
      send_request(OP_QUAD, 341, 170);
      send_request(OP_QUAD, 5, 9);
      random_requests(190);
      drain();

      // one segment each way, zero radii
      write_csr(CSR_MAJOR_RADIUS, 0);
      write_csr(CSR_MINOR_RADIUS, 0);
      write_csr(CSR_MAJOR_SEGMENTS, 1);
      write_csr(CSR_MINOR_SEGMENTS, 1);
      send_request(OP_VERTEX, 1, 1);
      send_request(OP_QUAD, 1, 1);
      random_requests(170);
      drain();

      // largest grid and radii
      write_csr(CSR_MAJOR_RADIUS, 32'hFFFF);
      write_csr(CSR_MINOR_RADIUS, 32'hFFFF);
      write_csr(CSR_MAJOR_SEGMENTS, 256);
      write_csr(CSR_MINOR_SEGMENTS, 256);
      send_request(OP_VERTEX, 64, 192);
      send_request(OP_VERTEX, 256, 256);
      send_request(OP_QUAD, 255, 255);
      send_request(OP_QUAD, 511, 511);
      random_requests(200);
      drain();

      // zero count reads as one, oversized count as the maximum
      write_csr(CSR_MAJOR_RADIUS, $urandom);
      write_csr(CSR_MINOR_RADIUS, $urandom);
      write_csr(CSR_MAJOR_SEGMENTS, 0);
      write_csr(CSR_MINOR_SEGMENTS, 511);
      random_requests(200);
      drain();

      write_csr(CSR_MAJOR_SEGMENTS, 3);
      write_csr(CSR_MINOR_SEGMENTS, 5);
      random_requests(200);
      drain();

      // random settings
      repeat (2) begin
         write_csr(CSR_MAJOR_RADIUS, $urandom);
         write_csr(CSR_MINOR_RADIUS, $urandom);
         write_csr(CSR_MAJOR_SEGMENTS, $urandom_range(1, 511));
         write_csr(CSR_MINOR_SEGMENTS, $urandom_range(1, 511));
         random_requests(130);
         drain();
      end

      $display("Covered %0d vertex and %0d quad requests over seven register settings,",
               sb.vertex_count, sb.quad_count);
      $display("including one-segment, full-size and clamped grids; %0d mismatches.",
               sb.errors);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
